// ===== rtl/itpc_pkg.sv =====
`timescale 1ns / 1ps

package itpc_pkg;

   localparam int STACK_DEPTH_DEF = 16;

   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int SYM_W   = 3;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_USED_W = VALUE_W + OP_W;
   localparam int RSP_USED_W = VALUE_W + SYM_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // token kinds
   localparam logic [FUNC_W-1:0] FUNC_NUMBER = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_OPEN   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_OPER   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_END    = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   // stack symbols; operators use their own code
   localparam logic [SYM_W-1:0] SYM_PLUS  = 3'd0;
   localparam logic [SYM_W-1:0] SYM_MINUS = 3'd1;
   localparam logic [SYM_W-1:0] SYM_TIMES = 3'd2;
   localparam logic [SYM_W-1:0] SYM_DIV   = 3'd3;
   localparam logic [SYM_W-1:0] SYM_OPEN  = 3'd4;

   // precedence: '(' 0, plus/minus 1, times/divide 2
   function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] sym);
      logic [1:0] p;
      case (sym)
         SYM_OPEN:            p = 2'd0;
         SYM_PLUS, SYM_MINUS: p = 2'd1;
         SYM_TIMES, SYM_DIV:  p = 2'd2;
         default:             p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/itpc_stack_ram.sv =====
`timescale 1ns / 1ps

module itpc_stack_ram #(
   parameter int DEPTH  = itpc_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_W = 4
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [itpc_pkg::SYM_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [itpc_pkg::SYM_W-1:0]  rd_data
);

   logic [itpc_pkg::SYM_W-1:0] mem [DEPTH];
   logic [itpc_pkg::SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake               Payload
// req      in   req_tvalid/req_tready   tuser: func; tdata: number_value, operator_code
// rsp      out  rsp_tvalid/rsp_tready   tuser: out_kind; tdata: out_value, out_symbol; tlast
//
// A token is taken only when the converter is idle. A number is emitted and then flushed;
// an operator, paren or end pops stack entries, one pop per cycle unless the output stalls,
// set by the single read port of the stack RAM; an error is flushed the same way as a number.
// Reset is synchronous and leaves the stack empty; RAM contents are not cleared.
// A stalled rsp_tready holds the sequencer; one result waits in a pending register
// until it is known whether another result follows it.

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [itpc_pkg::REQ_DATA_W-1:0]   req_tdata,  // number_value, operator_code
   input  logic [itpc_pkg::FUNC_W-1:0]       req_tuser,  // func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [itpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_value, out_symbol
   output logic [itpc_pkg::KIND_W-1:0]       rsp_tuser,  // out_kind
   output logic                              rsp_tlast
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int SYM_W  = itpc_pkg::SYM_W;
   localparam int VAL_W  = itpc_pkg::VALUE_W;
   localparam int KIND_W = itpc_pkg::KIND_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FLUSH
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [itpc_pkg::FUNC_W-1:0]  tok_func_ff, tok_func_in;
   logic [VAL_W-1:0]             tok_value_ff, tok_value_in;
   logic [itpc_pkg::OP_W-1:0]    tok_op_ff, tok_op_in;

   logic                         pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]            pend_kind_ff, pend_kind_in;
   logic [VAL_W-1:0]             pend_value_ff, pend_value_in;
   logic [SYM_W-1:0]             pend_sym_ff, pend_sym_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]            rsp_kind_ff, rsp_kind_in;
   logic [VAL_W-1:0]             rsp_value_ff, rsp_value_in;
   logic [SYM_W-1:0]             rsp_sym_ff, rsp_sym_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         fwd_ff, fwd_in;
   logic [SYM_W-1:0]             fwd_sym_ff, fwd_sym_in;

   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [SYM_W-1:0]             wr_sym;
   logic [ADDR_W-1:0]            rd_addr;
   logic [SYM_W-1:0]             rd_sym;
   logic [CNT_W-1:0]             cnt_m1;

   logic                         out_free, step_ok, stack_empty, stack_full, pop_ok;
   logic [SYM_W-1:0]             top_sym, op_sym;
   logic                         emit, finish, go_flush;
   logic [KIND_W-1:0]            new_kind;
   logic [VAL_W-1:0]             new_value;
   logic [SYM_W-1:0]             new_sym;

   itpc_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_sym),
      .rd_addr (rd_addr),
      .rd_data (rd_sym)
   );

   // RAM read is registered; a push to the address being read is forwarded
   assign top_sym     = fwd_ff ? fwd_sym_ff : rd_sym;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign step_ok     = !pend_valid_ff || out_free;
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign op_sym      = {1'b0, tok_op_ff};
   assign pop_ok      = !stack_empty &&
                        (itpc_pkg::prec_of(top_sym) >= itpc_pkg::prec_of(op_sym));
   assign req_tready  = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      tok_func_in   = tok_func_ff;
      tok_value_in  = tok_value_ff;
      tok_op_in     = tok_op_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_value_in = pend_value_ff;
      pend_sym_in   = pend_sym_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_sym        = itpc_pkg::SYM_OPEN;
      emit          = 1'b0;
      finish        = 1'b0;
      go_flush      = 1'b0;
      new_kind      = itpc_pkg::KIND_ENTRY;
      new_value     = '0;
      new_sym       = top_sym;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               tok_func_in  = req_tuser;
               tok_value_in = req_tdata[VAL_W-1:0];
               tok_op_in    = req_tdata[itpc_pkg::REQ_USED_W-1:VAL_W];
               state_in     = S_RUN;
            end
         end
         S_RUN: begin
            if (step_ok) begin
               case (tok_func_ff)
                  itpc_pkg::FUNC_NUMBER: begin
                     emit      = 1'b1;
                     go_flush  = 1'b1;
                     new_kind  = itpc_pkg::KIND_NUMBER;
                     new_value = tok_value_ff;
                     new_sym   = '0;
                  end
                  itpc_pkg::FUNC_OPEN: begin
                     if (stack_full) begin
                        emit     = 1'b1;
                        go_flush = 1'b1;
                        new_kind = itpc_pkg::KIND_ERROR;
                        new_sym  = '0;
                     end else begin
                        wr_en    = 1'b1;
                        wr_sym   = itpc_pkg::SYM_OPEN;
                        count_in = count_ff + 1'b1;
                        finish   = 1'b1;
                     end
                  end
                  itpc_pkg::FUNC_CLOSE: begin
                     if (stack_empty) begin
                        finish = 1'b1;
                     end else if (top_sym == itpc_pkg::SYM_OPEN) begin
                        // matching paren is dropped without a result
                        count_in = count_ff - 1'b1;
                        finish   = 1'b1;
                     end else begin
                        emit     = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  itpc_pkg::FUNC_OPER: begin
                     if (pop_ok) begin
                        emit     = 1'b1;
                        count_in = count_ff - 1'b1;
                     end else if (stack_full) begin
                        emit     = 1'b1;
                        go_flush = 1'b1;
                        new_kind = itpc_pkg::KIND_ERROR;
                        new_sym  = '0;
                     end else begin
                        wr_en    = 1'b1;
                        wr_sym   = op_sym;
                        count_in = count_ff + 1'b1;
                        finish   = 1'b1;
                     end
                  end
                  itpc_pkg::FUNC_END: begin
                     if (!stack_empty) begin
                        emit     = 1'b1;
                        count_in = count_ff - 1'b1;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase

               if (emit) begin
                  // the older pending result is now known not to be last
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_value_in = pend_value_ff;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = new_kind;
                  pend_value_in = new_value;
                  pend_sym_in   = new_sym;
                  if (go_flush) begin
                     state_in = S_FLUSH;
                  end
               end else if (finish) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_value_in = pend_value_ff;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b1;
                  end
                  pend_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_value_in  = pend_value_ff;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // keep the RAM output tracking the top of stack for the next cycle
      cnt_m1     = count_in - 1'b1;
      rd_addr    = (count_in == '0) ? '0 : cnt_m1[ADDR_W-1:0];
      fwd_in     = wr_en && (wr_addr == rd_addr);
      fwd_sym_in = wr_sym;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_ff        <= fwd_in;
      end
      tok_func_ff   <= tok_func_in;
      tok_value_ff  <= tok_value_in;
      tok_op_ff     <= tok_op_in;
      pend_kind_ff  <= pend_kind_in;
      pend_value_ff <= pend_value_in;
      pend_sym_ff   <= pend_sym_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_last_ff   <= rsp_last_in;
      fwd_sym_ff    <= fwd_sym_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{itpc_pkg::RSP_PAD_W{1'b0}}, rsp_sym_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> pend_valid_ff)
      else $error("flush without pending result");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == itpc_pkg::KIND_ERROR |-> rsp_tlast)
      else $error("overflow result not marked last");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("pending result left behind in idle");

endmodule
